[design/link_frame_seq_checksum_assert.svh]
// Assertion macros for the link framing block.
// Define ASSERT_OFF to compile every check to nothing.
`ifndef LINK_FRAME_SEQ_CHECKSUM_ASSERT_SVH
`define LINK_FRAME_SEQ_CHECKSUM_ASSERT_SVH
`ifndef ASSERT_OFF
`define LFSC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lfsc: same-cycle check failed");
`define LFSC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lfsc: next-cycle check failed");
`else
`define LFSC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define LFSC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

[design/lfsc_pkg.sv]
// Package for the link framing block: payload types, codes, checksum function.
// Used by link_frame_seq_checksum; depends on nothing.
`default_nettype none
package lfsc_pkg;

    localparam int PACKET_BYTES = 256;
    localparam int CNT_W        = $clog2(PACKET_BYTES + 3);
    localparam int LEN_W        = 9;
    localparam int RUN_MAX      = 6;
    localparam int RUN_W        = 3;

    localparam logic       OP_RX = 1'b0;
    localparam logic       OP_TX = 1'b1;

    localparam logic [1:0] KIND_RX_DATA = 2'd0;
    localparam logic [1:0] KIND_RX_END  = 2'd1;
    localparam logic [1:0] KIND_TX_BYTE = 2'd2;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_OK_FORCED = 3'd1;
    localparam logic [2:0] ST_SHORT     = 3'd2;
    localparam logic [2:0] ST_BAD_SUM   = 3'd3;
    localparam logic [2:0] ST_BAD_SEQ   = 3'd4;
    localparam logic [2:0] ST_LONG      = 3'd5;

    localparam logic [7:0] REG_START     = 8'd0;
    localparam logic [7:0] REG_STOP      = 8'd1;
    localparam logic [7:0] REG_SEQ_LOW   = 8'd2;
    localparam logic [7:0] REG_SEQ_HIGH  = 8'd3;
    localparam logic [7:0] REG_SEQ_FORCE = 8'd4;
    localparam logic [7:0] REG_SUM_SHIFT = 8'd5;
    localparam logic [7:0] REG_SUM_MASK  = 8'd6;
    localparam logic [7:0] REG_SUM_OFS   = 8'd7;

    localparam logic [7:0] RST_START     = 8'd1;
    localparam logic [7:0] RST_STOP      = 8'd2;
    localparam logic [7:0] RST_SEQ_LOW   = 8'd48;
    localparam logic [7:0] RST_SEQ_HIGH  = 8'd57;
    localparam logic [7:0] RST_SEQ_FORCE = 8'd33;
    localparam logic [2:0] RST_SUM_SHIFT = 3'd0;
    localparam logic [7:0] RST_SUM_MASK  = 8'd63;
    localparam logic [7:0] RST_SUM_OFS   = 8'd32;

    localparam logic [7:0] LINE_END = 8'h0d;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
        logic       end_of_payload;
        logic       force_seq;
    } t_in;

    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       value;
        logic [2:0]       status;
        logic [LEN_W-1:0] payload_length;
        logic             last;
    } t_out;

    function automatic logic [7:0] make_check(
        input logic [7:0] sum,
        input logic [2:0] shift,
        input logic [7:0] mask,
        input logic [7:0] offset
    );
        logic signed [7:0] sh;
        sh = $signed(sum) >>> shift;
        return (8'(sh) & mask) + offset;
    endfunction

endpackage
`default_nettype wire

[design/link_frame_seq_checksum.sv]
// Link framing block top level: receive deframing and transmit framing.
// Depends on lfsc_pkg and link_frame_seq_checksum_assert.svh.
//
// Usage:
//   Input channel (i_in_valid/o_in_ready, i_in_data) carries one byte per
//   transaction: op 0 is a received line byte, op 1 a payload byte to send.
//   Output channel (o_out_valid/i_out_ready, o_out_data) carries one result
//   per transaction; last marks the final result caused by one input.
//   Config channel (i_cfg_valid/o_cfg_ready) is always ready; write only
//   while the block is idle.
//   The first result of a transaction is valid the cycle after it
//   is accepted. An input causes 0 to 6 results, sent from a shift
//   register one per cycle while the receiver is ready; the next input is
//   accepted in the cycle the last of them is taken. Inputs that cause no
//   result are taken every cycle while no run is pending.
//   A stalled receiver holds the current result and blocks new input until
//   the pending run drains.
//   Reset (synchronous, active low) loads register defaults, sets both
//   sequence counters to the default low value and clears the frame state.
`default_nettype none
module link_frame_seq_checksum (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  lfsc_pkg::t_in    i_in_data,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output lfsc_pkg::t_out   o_out_data,
    input  wire              i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire [7:0]        i_cfg_index,
    input  wire [7:0]        i_cfg_data
);
    import lfsc_pkg::*;

    logic [7:0]       r_start, r_stop, r_seq_low, r_seq_high, r_seq_force;
    logic [2:0]       r_sum_shift;
    logic [7:0]       r_sum_mask, r_sum_ofs;

    logic             r_rx_in_frame, n_rx_in_frame;
    logic [CNT_W-1:0] r_rx_count, n_rx_count;
    logic [7:0]       r_rx_held [2];
    logic [7:0]       n_rx_held [2];
    logic [7:0]       r_rx_sum, n_rx_sum;
    logic [7:0]       r_rx_exp, n_rx_exp;
    logic [7:0]       r_tx_seq, n_tx_seq;
    logic             r_tx_in_frame, n_tx_in_frame;
    logic [7:0]       r_tx_sum, n_tx_sum;

    logic             r_out_valid, n_out_valid;
    logic [RUN_W-1:0] r_rem, n_rem;
    logic [1:0]       r_kind, n_kind;
    logic [2:0]       r_status, n_status;
    logic [LEN_W-1:0] r_len, n_len;
    logic [7:0]       r_val [RUN_MAX];
    logic [7:0]       n_val [RUN_MAX];

    logic             in_acc, out_acc, cfg_acc;
    logic             is_term;
    logic [7:0]       rx_seq, rx_chk;
    logic [7:0]       tx_base, tx_sum1, tx_seqb, tx_sum2, tx_chk;
    logic [7:0]       tx_tail [5];

    assign o_cfg_ready = 1'b1;
    assign cfg_acc     = i_cfg_valid & o_cfg_ready;
    assign o_in_ready  = !r_out_valid || (i_out_ready && r_rem == RUN_W'(1));
    assign in_acc      = i_in_valid & o_in_ready;
    assign out_acc     = r_out_valid & i_out_ready;

    assign is_term = (i_in_data.data == r_stop) || (i_in_data.data == r_start);
    assign rx_seq  = r_rx_held[0];
    assign rx_chk  = make_check(r_rx_sum + rx_seq, r_sum_shift, r_sum_mask, r_sum_ofs);
    assign tx_base = r_tx_in_frame ? r_tx_sum : 8'd0;
    assign tx_sum1 = tx_base + i_in_data.data;
    assign tx_seqb = i_in_data.force_seq ? r_seq_force : r_tx_seq;
    assign tx_sum2 = tx_sum1 + tx_seqb;
    assign tx_chk  = make_check(tx_sum2, r_sum_shift, r_sum_mask, r_sum_ofs);

    assign tx_tail[0] = i_in_data.data;
    assign tx_tail[1] = tx_seqb;
    assign tx_tail[2] = tx_chk;
    assign tx_tail[3] = r_stop;
    assign tx_tail[4] = LINE_END;

    always_comb begin
        n_rx_in_frame = r_rx_in_frame;
        n_rx_count    = r_rx_count;
        n_rx_held     = r_rx_held;
        n_rx_sum      = r_rx_sum;
        n_rx_exp      = r_rx_exp;
        n_tx_seq      = r_tx_seq;
        n_tx_in_frame = r_tx_in_frame;
        n_tx_sum      = r_tx_sum;
        n_out_valid   = r_out_valid;
        n_rem         = r_rem;
        n_kind        = r_kind;
        n_status      = r_status;
        n_len         = r_len;
        n_val         = r_val;

        if (out_acc) begin
            if (r_rem > RUN_W'(1)) begin
                for (int i = 0; i < RUN_MAX - 1; i++) begin
                    n_val[i] = r_val[i + 1];
                end
                n_rem = r_rem - RUN_W'(1);
            end else begin
                n_out_valid = 1'b0;
                n_rem       = '0;
            end
        end

        if (in_acc) begin
            if (i_in_data.op == OP_RX) begin
                if (!r_rx_in_frame) begin
                    if (i_in_data.data == r_start) begin
                        n_rx_in_frame = 1'b1;
                        n_rx_count    = '0;
                        n_rx_sum      = 8'd0;
                    end
                end else if (is_term) begin
                    n_rx_in_frame = 1'b0;
                    n_out_valid   = 1'b1;
                    n_rem         = RUN_W'(1);
                    n_kind        = KIND_RX_END;
                    n_val[0]      = 8'd0;
                    n_len         = '0;
                    if (r_rx_count < CNT_W'(2)) begin
                        n_status = ST_SHORT;
                    end else begin
                        n_len = LEN_W'(r_rx_count - CNT_W'(2));
                        if (rx_chk != r_rx_held[1]) begin
                            n_status = ST_BAD_SUM;
                        end else if (rx_seq == r_seq_force) begin
                            n_rx_exp = r_seq_low;
                            n_tx_seq = r_seq_low;
                            n_status = ST_OK_FORCED;
                        end else if (rx_seq != r_rx_exp) begin
                            n_status = ST_BAD_SEQ;
                        end else begin
                            n_rx_exp = (r_rx_exp == r_seq_high) ? r_seq_low
                                                                : r_rx_exp + 8'd1;
                            n_status = ST_OK;
                        end
                    end
                end else if (r_rx_count >= CNT_W'(PACKET_BYTES + 2)) begin
                    n_rx_in_frame = 1'b0;
                    n_out_valid   = 1'b1;
                    n_rem         = RUN_W'(1);
                    n_kind        = KIND_RX_END;
                    n_val[0]      = 8'd0;
                    n_status      = ST_LONG;
                    n_len         = LEN_W'(PACKET_BYTES);
                end else begin
                    if (r_rx_count >= CNT_W'(2)) begin
                        n_out_valid  = 1'b1;
                        n_rem        = RUN_W'(1);
                        n_kind       = KIND_RX_DATA;
                        n_val[0]     = r_rx_held[0];
                        n_status     = ST_OK;
                        n_len        = '0;
                        n_rx_sum     = r_rx_sum + r_rx_held[0];
                        n_rx_held[0] = r_rx_held[1];
                        n_rx_held[1] = i_in_data.data;
                    end else if (r_rx_count[0]) begin
                        n_rx_held[1] = i_in_data.data;
                    end else begin
                        n_rx_held[0] = i_in_data.data;
                    end
                    n_rx_count = r_rx_count + CNT_W'(1);
                end
            end else begin
                n_out_valid = 1'b1;
                n_kind      = KIND_TX_BYTE;
                n_status    = ST_OK;
                n_len       = '0;
                if (!r_tx_in_frame) begin
                    n_val[0] = r_start;
                    for (int i = 0; i < RUN_MAX - 1; i++) begin
                        n_val[i + 1] = tx_tail[i];
                    end
                end else begin
                    for (int i = 0; i < RUN_MAX - 1; i++) begin
                        n_val[i] = tx_tail[i];
                    end
                    n_val[RUN_MAX - 1] = 8'd0;
                end
                n_rem = (r_tx_in_frame ? RUN_W'(1) : RUN_W'(2))
                      + (i_in_data.end_of_payload ? RUN_W'(4) : RUN_W'(0));
                if (i_in_data.end_of_payload) begin
                    if (tx_seqb == r_seq_force) begin
                        n_tx_seq = r_seq_low;
                        n_rx_exp = r_seq_low;
                    end else begin
                        n_tx_seq = (tx_seqb == r_seq_high) ? r_seq_low : tx_seqb + 8'd1;
                    end
                    n_tx_in_frame = 1'b0;
                    n_tx_sum      = 8'd0;
                end else begin
                    n_tx_in_frame = 1'b1;
                    n_tx_sum      = tx_sum1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start       <= RST_START;
            r_stop        <= RST_STOP;
            r_seq_low     <= RST_SEQ_LOW;
            r_seq_high    <= RST_SEQ_HIGH;
            r_seq_force   <= RST_SEQ_FORCE;
            r_sum_shift   <= RST_SUM_SHIFT;
            r_sum_mask    <= RST_SUM_MASK;
            r_sum_ofs     <= RST_SUM_OFS;
            r_rx_in_frame <= 1'b0;
            r_rx_count    <= '0;
            r_rx_sum      <= 8'd0;
            r_rx_exp      <= RST_SEQ_LOW;
            r_tx_seq      <= RST_SEQ_LOW;
            r_tx_in_frame <= 1'b0;
            r_tx_sum      <= 8'd0;
            r_out_valid   <= 1'b0;
            r_rem         <= '0;
        end else begin
            if (cfg_acc) begin
                unique case (i_cfg_index)
                    REG_START:     r_start     <= i_cfg_data;
                    REG_STOP:      r_stop      <= i_cfg_data;
                    REG_SEQ_LOW:   r_seq_low   <= i_cfg_data;
                    REG_SEQ_HIGH:  r_seq_high  <= i_cfg_data;
                    REG_SEQ_FORCE: r_seq_force <= i_cfg_data;
                    REG_SUM_SHIFT: r_sum_shift <= i_cfg_data[2:0];
                    REG_SUM_MASK:  r_sum_mask  <= i_cfg_data;
                    REG_SUM_OFS:   r_sum_ofs   <= i_cfg_data;
                    default: ;
                endcase
            end
            r_rx_in_frame <= n_rx_in_frame;
            r_rx_count    <= n_rx_count;
            r_rx_sum      <= n_rx_sum;
            r_rx_exp      <= n_rx_exp;
            r_tx_seq      <= n_tx_seq;
            r_tx_in_frame <= n_tx_in_frame;
            r_tx_sum      <= n_tx_sum;
            r_out_valid   <= n_out_valid;
            r_rem         <= n_rem;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rx_held <= n_rx_held;
        r_kind    <= n_kind;
        r_status  <= n_status;
        r_len     <= n_len;
        r_val     <= n_val;
    end

    assign o_out_valid               = r_out_valid;
    assign o_out_data.kind           = r_kind;
    assign o_out_data.value          = r_val[0];
    assign o_out_data.status         = r_status;
    assign o_out_data.payload_length = r_len;
    assign o_out_data.last           = (r_rem == RUN_W'(1));

`include "link_frame_seq_checksum_assert.svh"

    `LFSC_ASSERT_IMP(a_valid_has_run, i_clk, i_rst_n, r_out_valid,
                     r_rem != '0 && r_rem <= RUN_W'(RUN_MAX))
    `LFSC_ASSERT_IMP(a_rx_single, i_clk, i_rst_n, r_out_valid && r_kind != KIND_TX_BYTE,
                     r_rem == RUN_W'(1))
    `LFSC_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1,
                     r_rx_count <= CNT_W'(PACKET_BYTES + 2))
    `LFSC_ASSERT_NXT(a_tx_tail_run, i_clk, i_rst_n,
                     in_acc && i_in_data.op == OP_TX && i_in_data.end_of_payload,
                     r_out_valid && r_rem >= RUN_W'(5) && !r_tx_in_frame)
    `LFSC_ASSERT_NXT(a_rx_end_hunts, i_clk, i_rst_n,
                     in_acc && i_in_data.op == OP_RX && r_rx_in_frame && is_term,
                     !r_rx_in_frame && r_out_valid && r_kind == KIND_RX_END)

endmodule
`default_nettype wire
